// File: src/tcc_pkg.sv
package tcc_pkg;

	localparam int PIXEL_COLUMNS = 128;
	localparam int PIXEL_ROWS    = 64;
	localparam int FONT_WIDTH    = 6;
	localparam int FONT_HEIGHT   = 8;
	localparam int MARGIN        = 1;

	localparam int RAW_TW    = (PIXEL_COLUMNS - MARGIN) / FONT_WIDTH;
	localparam int RAW_TH    = PIXEL_ROWS / FONT_HEIGHT;
	localparam int TEXT_COLS = (RAW_TW > 0) ? RAW_TW : 1;
	localparam int TEXT_ROWS = (RAW_TH > 0) ? RAW_TH : 1;

	localparam int CMD_W   = 1;
	localparam int CHAR_W  = 8;
	localparam int POS_W   = 16;
	localparam int KIND_W  = 2;
	localparam int X_W     = 7;
	localparam int Y_W     = 6;
	localparam int COL_W   = 5;
	localparam int ROW_W   = 3;
	localparam int MAX_RES = 4;
	localparam int CNT_W   = 3;
	localparam int IDX_W   = 2;

	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;

	// reciprocal of the column count, exact for every 16-bit position
	localparam int RECIP_SH = 21;
	localparam int RECIP    = ((2 ** RECIP_SH) + TEXT_COLS - 1) / TEXT_COLS;
	localparam int RECIP_W  = 18;
	localparam int QUOT_W   = POS_W + RECIP_W - RECIP_SH;

	localparam logic [CMD_W-1:0]  CMD_PUT     = 1'b0;
	localparam logic [CMD_W-1:0]  CMD_SET_POS = 1'b1;
	localparam logic [CHAR_W-1:0] NEWLINE     = 8'd10;

	localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [X_W-1:0]    x_pixel;
		logic [Y_W-1:0]    y_pixel;
		logic [CHAR_W-1:0] glyph;
		logic [Y_W-1:0]    start_line;
		logic              last;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [CNT_W-1:0]   cnt;
	} batch_t;

	function automatic logic [Y_W-1:0] row_y(input logic [ROW_W-1:0] row,
		input logic [Y_W-1:0] off);
		logic [Y_W:0] sum;
		sum = (Y_W+1)'(row) * (Y_W+1)'(FONT_HEIGHT) + (Y_W+1)'(off);
		if (sum >= (Y_W+1)'(PIXEL_ROWS)) begin
			sum = sum - (Y_W+1)'(PIXEL_ROWS);
		end
		return sum[Y_W-1:0];
	endfunction

	function automatic logic [Y_W-1:0] next_off(input logic [Y_W-1:0] off);
		logic [Y_W:0] sum;
		sum = (Y_W+1)'(off) + (Y_W+1)'(FONT_HEIGHT);
		if (sum >= (Y_W+1)'(PIXEL_ROWS)) begin
			sum = sum - (Y_W+1)'(PIXEL_ROWS);
		end
		return sum[Y_W-1:0];
	endfunction

	function automatic logic [X_W-1:0] col_x(input logic [COL_W-1:0] col);
		return X_W'(MARGIN) + X_W'(col) * X_W'(FONT_WIDTH);
	endfunction

endpackage

// File: src/tcc_pos_split.sv
module tcc_pos_split import tcc_pkg::*; (
	input  logic [POS_W-1:0] position,
	output logic [COL_W-1:0] col,
	output logic [ROW_W-1:0] row
);

	logic [POS_W+RECIP_W-1:0] prod;
	logic [QUOT_W-1:0]        quot;
	logic [POS_W-1:0]         rem;

	assign prod = (POS_W+RECIP_W)'(position) * (POS_W+RECIP_W)'(RECIP);
	assign quot = prod[POS_W+RECIP_W-1:RECIP_SH];
	assign rem  = position - POS_W'(quot) * POS_W'(TEXT_COLS);
	assign col  = rem[COL_W-1:0];
	assign row  = ROW_W'(quot % TEXT_ROWS);

endmodule

// File: src/tcc_engine.sv
module tcc_engine import tcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [CMD_W-1:0]  command,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [POS_W-1:0]  position,
	output batch_t            batch
);

	logic [COL_W-1:0] col_q, col_d, set_col, col1;
	logic [ROW_W-1:0] row_q, row_d, set_row;
	logic [Y_W-1:0]   off_q, off_d, off1, off2;
	logic             owed_q, owed_d;
	logic             row_last;
	logic [COL_W:0]   col_inc;
	logic [CNT_W-1:0] k;
	res_t             blank;

	tcc_pos_split u_split (
		.position(position),
		.col     (set_col),
		.row     (set_row)
	);

	assign row_last = !(({1'b0, row_q} + (ROW_W+1)'(1)) < (ROW_W+1)'(TEXT_ROWS));
	assign off1     = owed_q ? next_off(off_q) : off_q;
	assign col1     = owed_q ? '0 : col_q;
	assign off2     = next_off(off1);
	assign col_inc  = {1'b0, col1} + (COL_W+1)'(1);

	always_comb begin
		blank = '0;
		batch = '0;
		k     = '0;
		col_d  = col_q;
		row_d  = row_q;
		off_d  = off_q;
		owed_d = owed_q;
		if (command == CMD_SET_POS) begin
			col_d  = set_col;
			row_d  = set_row;
			off_d  = '0;
			owed_d = 1'b0;
		end else begin
			owed_d = 1'b0;
			off_d  = off1;
			col_d  = col1;
			if (owed_q) begin
				batch.res[k[IDX_W-1:0]]            = blank;
				batch.res[k[IDX_W-1:0]].kind       = KIND_START;
				batch.res[k[IDX_W-1:0]].start_line = off1;
				k = k + CNT_W'(1);
				batch.res[k[IDX_W-1:0]]         = blank;
				batch.res[k[IDX_W-1:0]].kind    = KIND_CLEAR;
				batch.res[k[IDX_W-1:0]].x_pixel = X_W'(MARGIN);
				batch.res[k[IDX_W-1:0]].y_pixel = row_y(row_q, off1);
				k = k + CNT_W'(1);
			end
			if (char_code == NEWLINE) begin
				col_d = '0;
				if (!row_last) begin
					row_d = row_q + ROW_W'(1);
					batch.res[k[IDX_W-1:0]]         = blank;
					batch.res[k[IDX_W-1:0]].kind    = KIND_CLEAR;
					batch.res[k[IDX_W-1:0]].x_pixel = X_W'(MARGIN);
					batch.res[k[IDX_W-1:0]].y_pixel = row_y(row_q + ROW_W'(1), off1);
					k = k + CNT_W'(1);
				end else begin
					off_d = off2;
					batch.res[k[IDX_W-1:0]]            = blank;
					batch.res[k[IDX_W-1:0]].kind       = KIND_START;
					batch.res[k[IDX_W-1:0]].start_line = off2;
					k = k + CNT_W'(1);
					batch.res[k[IDX_W-1:0]]         = blank;
					batch.res[k[IDX_W-1:0]].kind    = KIND_CLEAR;
					batch.res[k[IDX_W-1:0]].x_pixel = X_W'(MARGIN);
					batch.res[k[IDX_W-1:0]].y_pixel = row_y(row_q, off2);
					k = k + CNT_W'(1);
				end
			end else begin
				batch.res[k[IDX_W-1:0]]         = blank;
				batch.res[k[IDX_W-1:0]].kind    = KIND_DRAW;
				batch.res[k[IDX_W-1:0]].x_pixel = col_x(col1);
				batch.res[k[IDX_W-1:0]].y_pixel = row_y(row_q, off1);
				batch.res[k[IDX_W-1:0]].glyph   = char_code;
				k = k + CNT_W'(1);
				if (col_inc >= (COL_W+1)'(TEXT_COLS)) begin
					col_d = '0;
					if (!row_last) begin
						row_d = row_q + ROW_W'(1);
					end else begin
						owed_d = 1'b1;
					end
				end else begin
					col_d = col_inc[COL_W-1:0];
				end
			end
		end
		batch.cnt = k;
		for (int i = 0; i < MAX_RES; i++) begin
			batch.res[i].last = (CNT_W'(i + 1) == k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			off_q  <= '0;
			owed_q <= 1'b0;
		end else if (advance) begin
			col_q  <= col_d;
			row_q  <= row_d;
			off_q  <= off_d;
			owed_q <= owed_d;
		end
	end

endmodule

// File: src/tcc_out_queue.sv
module tcc_out_queue import tcc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  batch_t batch,
	input  logic   pop,
	output logic   free,
	output logic   valid,
	output res_t   head
);

	res_t [MAX_RES-1:0] res_q;
	logic [CNT_W-1:0]   cnt_q;

	assign valid = (cnt_q != '0);
	assign head  = res_q[0];
	assign free  = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= batch.cnt;
		end else if (pop && valid) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// shift toward the head on every pop of a valid result; a load replaces the batch
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= batch.res;
		end else if (pop && valid) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
			res_q[MAX_RES-1] <= '0;
		end
	end

endmodule

// File: src/text_console_cursor_scroll.sv
// An item's first result is offered once it has passed the input register and been
// loaded into the result queue. Throughput: one item per cycle while each item yields
// at most one result and the output is ready; more results (up to four) hold the input.
// Work per item is one pass of logic between the input register and the
// result queue; the result queue is the only stall point.
// Reset clears the cursor, start line, owed scroll flag and empties both stages.
module text_console_cursor_scroll import tcc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,  // char_code[7:0], position[23:8]
	input  logic [CMD_W-1:0]    s_axis_tuser,  // command
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,  // x_pixel, y_pixel, glyph, start_line, zero pad
	output logic [KIND_W-1:0]   m_axis_tuser,  // kind
	output logic                m_axis_tlast
);

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [CHAR_W-1:0] char_s1;
	logic [POS_W-1:0]  pos_s1;
	logic              consume;
	logic              q_free;
	logic              q_valid;
	batch_t            batch;
	res_t              head;

	assign consume       = valid_s1 && q_free;
	assign s_axis_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1  <= s_axis_tuser;
			char_s1 <= s_axis_tdata[CHAR_W-1:0];
			pos_s1  <= s_axis_tdata[CHAR_W+POS_W-1:CHAR_W];
		end
	end

	tcc_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (consume),
		.command  (cmd_s1),
		.char_code(char_s1),
		.position (pos_s1),
		.batch    (batch)
	);

	tcc_out_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (consume),
		.batch (batch),
		.pop   (m_axis_tready),
		.free  (q_free),
		.valid (q_valid),
		.head  (head)
	);

	assign m_axis_tvalid = q_valid;
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;
	assign m_axis_tdata  = M_DATA_W'({head.start_line, head.glyph, head.y_pixel, head.x_pixel});

`ifndef SYNTHESIS
	a_load_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		consume |-> (!m_axis_tvalid || (m_axis_tready && m_axis_tlast)))
		else $error("batch loaded over undelivered results");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == KIND_DRAW || m_axis_tuser == KIND_START ||
			m_axis_tuser == KIND_CLEAR))
		else $error("illegal result kind");

	a_batch_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && batch.cnt != '0) |->
			batch.res[batch.cnt[IDX_W-1:0] - IDX_W'(1)].last)
		else $error("batch does not end with last");
`endif

endmodule
